FILE: design/prl_pkg.sv
`default_nettype none

package prl_pkg;

  // Default number of stored values and the longest dump that is emitted.
  localparam int CAPACITY_DEF = 16;
  localparam int MAX_RESULTS  = 16;

  // Field widths fixed by the interface.
  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 8;

  // Command codes; code 7 has no meaning and is reported invalid.
  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_DUMP      = 3'd6
  } cmd_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Which slot an insert or delete works on.
  typedef enum logic [1:0] {
    SEL_FRONT = 2'd0,
    SEL_BACK  = 2'd1,
    SEL_POS   = 2'd2
  } sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    ins_en;
    logic    del_en;
    logic    rot_en;
    sel_t    sel;
    logic    res_load;
    status_t res_status;
    logic    res_elem;
    logic    res_last;
    logic    k_clr;
    logic    k_inc;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic ins_pos_ok;
    logic del_pos_ok;
    logic k_last;
    logic k_emit;
    logic k_emit_last;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: design/positional_ring_list.sv
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells.
// Each input word is one command (in_tuser): insert at front, back or a 1-based
// position, delete at front, back or a position, or dump. Every command but a
// non-empty dump returns one result word; a dump returns one word per stored
// value, front to back (at most 16), the final one marked by out_tlast. Inserts,
// deletes and rejected commands are done in the cycle that takes them, since
// all cells shift in parallel. A dump takes the command, then makes one ring
// rotation per cycle while the output does not stall, reading the front cell,
// which leaves the order as it was. A new command is taken whenever the block
// is not dumping and the result register is empty or being read.
module positional_ring_list
  import prl_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // value[31:0], position[39:32]
  input  wire logic [2:0]  in_tuser,   // command[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // status[1:0], count[9:2], element[41:10], zero
  output logic             out_tlast   // is_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [STATUS_W-1:0]       res_status;
  logic [COUNT_W-1:0]        res_count;
  logic signed [VALUE_W-1:0] res_element;
  logic                      res_last;

  prl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_command (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  prl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_value    (in_tdata[31:0]),
    .in_position (in_tdata[39:32]),
    .cmd         (cmd),
    .stat        (stat),
    .res_status  (res_status),
    .res_count   (res_count),
    .res_element (res_element),
    .res_last    (res_last)
  );

  // Pack the result word.
  assign out_tdata = {6'b0, res_element, res_count, res_status};
  assign out_tlast = res_last;

  // The reported count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[9:2]) <= 32'(CAPACITY)))
    else $error("result count above capacity");

  // Any command other than dump gives its result word in the next cycle.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser != CMD_DUMP) |=> (out_tvalid && out_tlast))
    else $error("missing result after command");

  // A rejected command ends its run and carries no element.
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] != ST_OK) |-> (out_tlast && out_tdata[41:10] == '0))
    else $error("rejected command with element or open run");

  // No command is taken while a dump is under way.
  a_dump_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == CMD_DUMP && !stat.cnt_zero) |=> !in_tready)
    else $error("command accepted during dump");

endmodule

`default_nettype wire

FILE: design/prl_datapath.sv
`default_nettype none

module prl_datapath
  import prl_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic signed [VALUE_W-1:0]  in_value,
  input  wire logic        [POS_W-1:0]    in_position,
  input  wire dp_cmd_t                    cmd,
  output dp_stat_t                        stat,
  output logic             [STATUS_W-1:0] res_status,
  output logic             [COUNT_W-1:0]  res_count,
  output logic signed      [VALUE_W-1:0]  res_element,
  output logic                            res_last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = 10;

  // Cell array, stored count and dump step counter.
  logic signed [VALUE_W-1:0] cell_r [CAPACITY];
  logic signed [VALUE_W-1:0] cell_nxt [CAPACITY];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;

  // Result register.
  logic [STATUS_W-1:0]       res_status_r;
  logic [COUNT_W-1:0]        res_count_r;
  logic signed [VALUE_W-1:0] res_element_r;
  logic                      res_last_r;

  logic [CMP_W-1:0] cnt_w, pos_w, k_w, ins_idx_w, del_idx_w;
  logic [IDX_W-1:0] ins_idx, del_idx, back_idx;

  assign cnt_w = CMP_W'(count_r);
  assign pos_w = CMP_W'(in_position);
  assign k_w   = CMP_W'(k_r);

  // Range checks on the requested position and on the stored count.
  always_comb begin
    stat.cnt_zero    = (count_r == '0);
    stat.cnt_full    = (cnt_w == CMP_W'(CAPACITY));
    stat.ins_pos_ok  = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1));
    stat.del_pos_ok  = (pos_w != '0) && (pos_w <= cnt_w);
    stat.k_last      = (k_w + CMP_W'(1) == cnt_w);
    stat.k_emit      = (k_w < CMP_W'(MAX_RESULTS));
    stat.k_emit_last = (k_w + CMP_W'(1) == cnt_w) ||
                       (k_w + CMP_W'(1) == CMP_W'(MAX_RESULTS));
  end

  // Slot index for the insert or delete; only used once the range check passed.
  always_comb begin
    ins_idx_w = '0;
    del_idx_w = '0;
    case (cmd.sel)
      SEL_FRONT: begin
        ins_idx_w = '0;
        del_idx_w = '0;
      end
      SEL_BACK: begin
        ins_idx_w = cnt_w;
        del_idx_w = cnt_w - CMP_W'(1);
      end
      SEL_POS: begin
        ins_idx_w = pos_w - CMP_W'(1);
        del_idx_w = pos_w - CMP_W'(1);
      end
      default: begin
        ins_idx_w = '0;
        del_idx_w = '0;
      end
    endcase
  end

  assign ins_idx  = ins_idx_w[IDX_W-1:0];
  assign del_idx  = del_idx_w[IDX_W-1:0];
  assign back_idx = IDX_W'(cnt_w - CMP_W'(1));

  // Each cell picks its next value from itself, a neighbor, the front cell
  // (ring rotation) or the new value.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] prev_v, next_v;
    if (i > 0) begin : g_prev
      assign prev_v = cell_r[i-1];
    end else begin : g_prev0
      assign prev_v = cell_r[i];
    end
    if (i < CAPACITY - 1) begin : g_next
      assign next_v = cell_r[i+1];
    end else begin : g_nextn
      assign next_v = cell_r[i];
    end

    always_comb begin
      cell_nxt[i] = cell_r[i];
      if (cmd.ins_en) begin
        if (IDX_W'(i) > ins_idx) begin
          cell_nxt[i] = prev_v;
        end else if (IDX_W'(i) == ins_idx) begin
          cell_nxt[i] = in_value;
        end
      end else if (cmd.del_en) begin
        if (IDX_W'(i) >= del_idx) begin
          cell_nxt[i] = next_v;
        end
      end else if (cmd.rot_en) begin
        if (IDX_W'(i) == back_idx) begin
          cell_nxt[i] = cell_r[0];
        end else begin
          cell_nxt[i] = next_v;
        end
      end
    end

    always_ff @(posedge clk) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  // Count and dump counter.
  always_comb begin
    count_nxt = count_r;
    if (cmd.ins_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.del_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
    k_nxt = k_r;
    if (cmd.k_clr) begin
      k_nxt = '0;
    end else if (cmd.k_inc) begin
      k_nxt = k_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      k_r     <= '0;
    end else begin
      count_r <= count_nxt;
      k_r     <= k_nxt;
    end
  end

  // Result register, loaded with the count after the command.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status_r  <= cmd.res_status;
      res_count_r   <= COUNT_W'(count_nxt);
      res_element_r <= cmd.res_elem ? cell_r[0] : '0;
      res_last_r    <= cmd.res_last;
    end
  end

  assign res_status  = res_status_r;
  assign res_count   = res_count_r;
  assign res_element = res_element_r;
  assign res_last    = res_last_r;

endmodule

`default_nettype wire

FILE: design/prl_ctrl.sv
`default_nettype none

module prl_ctrl
  import prl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [CMD_W-1:0] in_command,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  input  wire dp_stat_t         stat,
  output dp_cmd_t               cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   in_acc;

  // The result register can take a word when empty or being drained.
  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE) && slot_free;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // Command decode and dump sequencing.
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.sel        = SEL_FRONT;
    cmd.res_status = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.res_load = 1'b1;
          cmd.res_last = 1'b1;
          case (cmd_t'(in_command))
            CMD_INS_FRONT, CMD_INS_BACK: begin
              cmd.sel = (cmd_t'(in_command) == CMD_INS_FRONT) ? SEL_FRONT : SEL_BACK;
              if (stat.cnt_full) begin
                cmd.res_status = ST_FULL;
              end else begin
                cmd.ins_en = 1'b1;
              end
            end
            CMD_INS_AT: begin
              cmd.sel = SEL_POS;
              if (!stat.ins_pos_ok) begin
                cmd.res_status = ST_INVALID;
              end else if (stat.cnt_full) begin
                cmd.res_status = ST_FULL;
              end else begin
                cmd.ins_en = 1'b1;
              end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK: begin
              cmd.sel = (cmd_t'(in_command) == CMD_DEL_FRONT) ? SEL_FRONT : SEL_BACK;
              if (stat.cnt_zero) begin
                cmd.res_status = ST_EMPTY;
              end else begin
                cmd.del_en = 1'b1;
              end
            end
            CMD_DEL_AT: begin
              cmd.sel = SEL_POS;
              if (!stat.del_pos_ok) begin
                cmd.res_status = ST_INVALID;
              end else begin
                cmd.del_en = 1'b1;
              end
            end
            CMD_DUMP: begin
              // An empty dump gives one word; otherwise the ring walk starts.
              if (!stat.cnt_zero) begin
                cmd.res_load = 1'b0;
                cmd.k_clr    = 1'b1;
                state_nxt    = S_DUMP;
              end
            end
            default: begin
              cmd.res_status = ST_INVALID;
            end
          endcase
        end
      end
      S_DUMP: begin
        // Rotate the ring one place per step; the first MAX_RESULTS fronts go out.
        if (!stat.k_emit || slot_free) begin
          cmd.rot_en   = 1'b1;
          cmd.k_inc    = 1'b1;
          cmd.res_load = stat.k_emit;
          cmd.res_elem = 1'b1;
          cmd.res_last = stat.k_emit_last;
          if (stat.k_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire
